>>> rtl/core/path_threshold_transition_finder_unit_assert.svh
// Assertion macros for the checker file.
`ifndef PATH_THRESHOLD_TRANSITION_FINDER_UNIT_ASSERT_SVH
`define PATH_THRESHOLD_TRANSITION_FINDER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ptt_pkg.sv
`default_nettype none
package ptt_pkg;

    localparam int PIX_W         = 8;
    localparam int COUNT_LIMIT   = 1024;
    localparam int COUNT_W       = $clog2(COUNT_LIMIT + 1);
    localparam int MAXD_W        = 10;
    localparam int CMP_W         = (COUNT_W > MAXD_W) ? COUNT_W : MAXD_W;
    localparam int FRACTION_BITS = 8;
    localparam int FRAC_W        = FRACTION_BITS + 1;
    localparam int NUM_W         = PIX_W + FRACTION_BITS;
    localparam int DIV_STEPS     = NUM_W;
    localparam int STEP_W        = $clog2(DIV_STEPS);
    localparam int STATUS_W      = 2;
    localparam int REG_IDX_W     = 2;
    localparam int CFG_W         = 10;

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SEEK_DARK    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd2;

    localparam logic [PIX_W-1:0]  THRESHOLD_RST    = 8'd128;
    localparam logic              SEEK_DARK_RST    = 1'b1;
    localparam logic [MAXD_W-1:0] MAX_DISTANCE_RST = 10'd64;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND        = 2'd0,
        ST_START_TARGET = 2'd1,
        ST_LEFT_FRAME   = 2'd2,
        ST_TOO_FAR      = 2'd3
    } ptt_status_t;

    typedef enum logic {
        S_IDLE,
        S_DIVIDE
    } ptt_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic div_step;
        logic div_last;
    } ptt_cmd_t;

    // datapath to controller, decoded from the offered item
    typedef struct packed {
        logic emit_now;
        logic need_div;
    } ptt_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/ptt_datapath.sv
`default_nettype none
module ptt_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ptt_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]       cfg_data,
    input  logic [ptt_pkg::PIX_W-1:0]       pixel,
    input  logic                            start_req,
    input  logic                            column_step,
    input  logic                            row_step,
    input  logic                            in_frame,
    input  ptt_pkg::ptt_cmd_t               cmd,
    output ptt_pkg::ptt_stat_t              stat,
    output logic [ptt_pkg::STATUS_W-1:0]    status,
    output logic [ptt_pkg::COUNT_W-1:0]     columns,
    output logic [ptt_pkg::COUNT_W-1:0]     rows,
    output logic [ptt_pkg::FRAC_W-1:0]      fraction
);
    import ptt_pkg::*;

    logic [PIX_W-1:0]   threshold_reg;
    logic               seek_dark_reg;
    logic [MAXD_W-1:0]  max_dist_reg;

    logic               walking_reg;
    logic [COUNT_W-1:0] col_cnt_reg;
    logic [COUNT_W-1:0] row_cnt_reg;
    logic [PIX_W-1:0]   inside_reg;

    ptt_status_t        status_reg;
    logic [COUNT_W-1:0] columns_reg;
    logic [COUNT_W-1:0] rows_reg;
    logic [FRAC_W-1:0]  fraction_reg;

    logic [NUM_W-1:0]   num_sh_reg;
    logic [PIX_W-1:0]   den_reg;
    logic [PIX_W-1:0]   rem_reg;
    logic [PIX_W-1:0]   rem_next;
    logic [NUM_W-1:0]   quo_reg;
    logic [NUM_W-1:0]   quo_next;
    logic               den_zero_reg;
    logic [PIX_W:0]     rem_sh;

    logic               target;
    logic               in_range;
    logic               fix_over;
    logic [COUNT_W-1:0] cols_fix;
    logic [COUNT_W-1:0] rows_fix;
    logic [COUNT_W:0]   col_sum;
    logic [COUNT_W:0]   row_sum;
    logic [COUNT_W-1:0] col_adv;
    logic [COUNT_W-1:0] row_adv;
    logic [PIX_W-1:0]   num;
    logic [PIX_W-1:0]   den;

    logic               res_emit;
    logic               res_div;
    logic               advance;
    logic               open_walk;
    ptt_status_t        res_status;
    logic [COUNT_W-1:0] res_cols;
    logic [COUNT_W-1:0] res_rows;

    assign target = seek_dark_reg ? (pixel < threshold_reg) : (pixel >= threshold_reg);

    assign in_range = (CMP_W'(col_cnt_reg) <= CMP_W'(max_dist_reg))
                   && (CMP_W'(row_cnt_reg) <= CMP_W'(max_dist_reg));

    // single-step fix: a zero count takes the ending point's move
    assign cols_fix = ((col_cnt_reg == '0) && column_step) ? COUNT_W'(1) : col_cnt_reg;
    assign rows_fix = ((row_cnt_reg == '0) && row_step) ? COUNT_W'(1) : row_cnt_reg;
    assign fix_over = (CMP_W'(cols_fix) > CMP_W'(max_dist_reg))
                   || (CMP_W'(rows_fix) > CMP_W'(max_dist_reg));

    assign col_sum = {1'b0, col_cnt_reg} + {{COUNT_W{1'b0}}, column_step};
    assign row_sum = {1'b0, row_cnt_reg} + {{COUNT_W{1'b0}}, row_step};
    assign col_adv = (col_sum > (COUNT_W+1)'(COUNT_LIMIT)) ? COUNT_W'(COUNT_LIMIT)
                                                           : col_sum[COUNT_W-1:0];
    assign row_adv = (row_sum > (COUNT_W+1)'(COUNT_LIMIT)) ? COUNT_W'(COUNT_LIMIT)
                                                           : row_sum[COUNT_W-1:0];

    assign num = (pixel >= threshold_reg) ? (pixel - threshold_reg) : (threshold_reg - pixel);
    assign den = (pixel >= inside_reg) ? (pixel - inside_reg) : (inside_reg - pixel);

    always_comb
    begin
        res_emit   = 1'b0;
        res_div    = 1'b0;
        advance    = 1'b0;
        open_walk  = 1'b0;
        res_status = ST_FOUND;
        res_cols   = '0;
        res_rows   = '0;
        if (start_req)
        begin
            if (!in_frame)
            begin
                res_emit   = 1'b1;
                res_status = ST_LEFT_FRAME;
            end
            else if (target)
            begin
                res_emit   = 1'b1;
                res_status = ST_START_TARGET;
            end
            else
            begin
                open_walk = 1'b1;
            end
        end
        else if (walking_reg)
        begin
            if (in_frame && in_range && !target)
            begin
                advance = 1'b1;
            end
            else
            begin
                res_cols = cols_fix;
                res_rows = rows_fix;
                if (!in_frame)
                begin
                    res_emit   = 1'b1;
                    res_status = ST_LEFT_FRAME;
                end
                else if (fix_over)
                begin
                    res_emit   = 1'b1;
                    res_status = ST_TOO_FAR;
                end
                else
                begin
                    res_div = 1'b1;
                end
            end
        end
    end

    assign stat.emit_now = res_emit;
    assign stat.need_div = res_div;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    assign rem_sh = {rem_reg, num_sh_reg[NUM_W-1]};
    always_comb
    begin
        if (rem_sh >= {1'b0, den_reg})
        begin
            rem_next = PIX_W'(rem_sh - {1'b0, den_reg});
            quo_next = {quo_reg[NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[PIX_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            seek_dark_reg <= SEEK_DARK_RST;
            max_dist_reg  <= MAX_DISTANCE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:    threshold_reg <= cfg_data[PIX_W-1:0];
                REG_SEEK_DARK:    seek_dark_reg <= cfg_data[0];
                REG_MAX_DISTANCE: max_dist_reg  <= cfg_data[MAXD_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg <= 1'b0;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            inside_reg  <= '0;
        end
        else if (cmd.take)
        begin
            if (start_req)
            begin
                walking_reg <= open_walk;
                col_cnt_reg <= '0;
                row_cnt_reg <= '0;
                if (open_walk)
                begin
                    inside_reg <= pixel;
                end
            end
            else if (walking_reg)
            begin
                if (advance)
                begin
                    col_cnt_reg <= col_adv;
                    row_cnt_reg <= row_adv;
                    inside_reg  <= pixel;
                end
                else
                begin
                    walking_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && (res_emit || res_div))
        begin
            status_reg   <= res_status;
            columns_reg  <= res_cols;
            rows_reg     <= res_rows;
            fraction_reg <= '0;
        end
        else if (cmd.div_last)
        begin
            fraction_reg <= den_zero_reg ? '0 : quo_next[FRAC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && res_div)
        begin
            num_sh_reg   <= {num, {FRACTION_BITS{1'b0}}};
            den_reg      <= den;
            den_zero_reg <= (den == '0);
            rem_reg      <= '0;
            quo_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            num_sh_reg <= {num_sh_reg[NUM_W-2:0], 1'b0};
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
        end
    end

    assign status   = status_reg;
    assign columns  = columns_reg;
    assign rows     = rows_reg;
    assign fraction = fraction_reg;

endmodule
`default_nettype wire

>>> rtl/core/ptt_ctrl.sv
`default_nettype none
module ptt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ptt_pkg::ptt_stat_t  stat,
    output ptt_pkg::ptt_cmd_t   cmd
);
    import ptt_pkg::*;

    ptt_state_t         state_reg;
    ptt_state_t         state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               take;
    logic               last;

    assign take = in_valid && in_ready;
    assign last = (state_reg == S_DIVIDE) && (step_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && stat.need_div)
                begin
                    state_next = S_DIVIDE;
                    step_next  = STEP_W'(DIV_STEPS - 1);
                end
            end
            S_DIVIDE:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
        cmd.take     = take;
        cmd.div_step = (state_reg == S_DIVIDE);
        cmd.div_last = last;
        priority if ((take && stat.emit_now) || last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> rtl/core/path_threshold_transition_finder_unit.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+--------------------------------------------------
// input     | in_valid / in_ready  | pixel, start_req, column_step, row_step, in_frame
// result    | out_valid / out_ready| status, columns, rows, fraction
// config    | cfg_we               | cfg_index, cfg_data
//
// A path pixel that opens or extends a walk, or comes with no walk open, gives no result.
// A result for a start point, a frame exit or an over-long walk is registered
// at its transfer. A found edge runs the 16-step restoring divider, one quotient
// bit a cycle, and its result is registered with the last quotient bit.
// Reset (rst_n low, asynchronous) closes any walk and loads the register defaults.
// in_ready drops while the divider runs and while a result waits unread.
`default_nettype none
module path_threshold_transition_finder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [ptt_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]       cfg_data,
    // path pixels
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ptt_pkg::PIX_W-1:0]       pixel,
    input  logic                            start_req,
    input  logic                            column_step,
    input  logic                            row_step,
    input  logic                            in_frame,
    // walk results
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ptt_pkg::STATUS_W-1:0]    status,
    output logic [ptt_pkg::COUNT_W-1:0]     columns,
    output logic [ptt_pkg::COUNT_W-1:0]     rows,
    output logic [ptt_pkg::FRAC_W-1:0]      fraction
);
    import ptt_pkg::*;

    ptt_cmd_t  cmd;
    ptt_stat_t stat;

    // Sequence transfers, the divider steps and the result register's valid.
    ptt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the registers, the walk state, the divider and the result register.
    // The item on offer is decoded here; the controller only sees whether it
    // ends a walk at once or needs the crossing fraction.
    ptt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel       (pixel),
        .start_req   (start_req),
        .column_step (column_step),
        .row_step    (row_step),
        .in_frame    (in_frame),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .columns     (columns),
        .rows        (rows),
        .fraction    (fraction)
    );

endmodule
`default_nettype wire

>>> rtl/core/ptt_checker.sv
`default_nettype none
`include "path_threshold_transition_finder_unit_assert.svh"
module ptt_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [ptt_pkg::STATUS_W-1:0]    status,
    input  logic [ptt_pkg::COUNT_W-1:0]     columns,
    input  logic [ptt_pkg::COUNT_W-1:0]     rows,
    input  logic [ptt_pkg::FRAC_W-1:0]      fraction
);
    import ptt_pkg::*;

    `PTT_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(status) && $stable(columns) && $stable(rows) && $stable(fraction), "result changed while stalled")
    `PTT_ASSERT_NOW(a_frac_only_found, out_valid && (status != ST_FOUND), fraction == '0, "fraction set without a found edge")
    `PTT_ASSERT_NOW(a_start_target_zero, out_valid && (status == ST_START_TARGET), (columns == '0) && (rows == '0), "start target result with moves")
    `PTT_ASSERT_NOW(a_no_take_on_stall, out_valid && !out_ready, !in_ready, "input taken while result stalled")

endmodule

bind path_threshold_transition_finder_unit ptt_checker u_ptt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .columns   (columns),
    .rows      (rows),
    .fraction  (fraction)
);
`default_nettype wire
